/* hdl/fvn_pkg.sv */
// shared types, constants and the fade table function of the fractal value noise block
// no dependencies; used by fractal_value_noise_2d and the testbench
package fvn_pkg;

  localparam int unsigned MaxOctavesDef   = 8;
  localparam int unsigned CosTableBitsDef = 10;

  localparam int unsigned CoordW   = 24;
  localparam int unsigned NoiseW   = 21;
  localparam int unsigned RowMulW  = 16;
  localparam int unsigned OctCntW  = 4;
  localparam int unsigned PersistW = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgRowMul  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgOctCnt  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPersist = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgMode    = 2'd3;

  localparam logic [RowMulW-1:0]  RowMulRst  = 16'd599;
  localparam logic [OctCntW-1:0]  OctCntRst  = 4'd8;
  localparam logic [PersistW-1:0] PersistRst = 16'd26214;

  localparam logic [31:0] HashMul = 32'd15731;
  localparam logic [31:0] HashAdd = 32'd789221;
  localparam logic [31:0] HashOff = 32'd1376312589;

  // lattice values in q30, smoothed and blended values in q34
  localparam int unsigned VW    = 36;
  localparam int unsigned FadeW = 17;
  localparam int unsigned AmpW  = 17;
  localparam int unsigned QuoW  = 20;

  localparam int SumMax = 1048575;
  localparam int SumMin = -1048576;

  typedef struct packed {
    logic signed [CoordW-1:0] coord_x;
    logic signed [CoordW-1:0] coord_y;
  } fvn_in_t;

  typedef struct packed {
    logic signed [NoiseW-1:0] noise_value;
    logic                     saturated;
  } fvn_out_t;

  // per-octave control that travels with each beat of the octave pipeline
  typedef struct packed {
    logic            first;
    logic            last;
    logic [AmpW-1:0] amp;
  } fvn_tag_t;

  // taylor cosine to x^16 in q30, fade (1 - cos)/2 in q0.16
  function automatic logic [FadeW-1:0] fade_half(input int k, input int bits);
    longint unsigned theta;
    longint unsigned x2;
    longint unsigned term;
    longint          c;
    longint          d;
    theta = (64'd3373259426 * longint'(k)) >> bits;
    x2    = (theta * theta) >> 30;
    term  = 64'd1 << 30;
    c     = 64'sd1 << 30;
    term = ((term * x2) >> 30) / 2;   c = c - longint'(term);
    term = ((term * x2) >> 30) / 12;  c = c + longint'(term);
    term = ((term * x2) >> 30) / 30;  c = c - longint'(term);
    term = ((term * x2) >> 30) / 56;  c = c + longint'(term);
    term = ((term * x2) >> 30) / 90;  c = c - longint'(term);
    term = ((term * x2) >> 30) / 132; c = c + longint'(term);
    term = ((term * x2) >> 30) / 182; c = c - longint'(term);
    term = ((term * x2) >> 30) / 240; c = c + longint'(term);
    d = (64'sd1 << 30) - c;
    if (d < 0) d = 0;
    return FadeW'((d + (64'sd1 << 14)) >>> 15);
  endfunction

  function automatic logic [FadeW-1:0] fade_entry(input int k, input int bits);
    int n;
    n = 1 << bits;
    if (k <= (n >> 1)) return fade_half(k, bits);
    return FadeW'(17'd65536 - fade_half(n - k, bits));
  endfunction

endpackage

/* hdl/fvn_div_pipe.sv */
// pipelined restoring divider, two quotient bits per stage, with an overflow check stage
// no package dependency; used by fractal_value_noise_2d
module fvn_div_pipe #(
  parameter int unsigned NUM_W  = 51,
  parameter int unsigned DEN_W  = 36,
  parameter int unsigned QUO_W  = 20,
  parameter int unsigned SIDE_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [QUO_W-1:0]  quo_o,
  output logic              ovf_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int unsigned CmpW   = ((NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W) + 1;
  localparam int unsigned Stages = (QUO_W + 1) / 2;

  logic              vld_q  [Stages+1];
  logic [CmpW-1:0]   rem_q  [Stages+1];
  logic [DEN_W-1:0]  den_q  [Stages+1];
  logic [QUO_W-1:0]  quo_q  [Stages+1];
  logic              ovf_q  [Stages+1];
  logic [SIDE_W-1:0] side_q [Stages+1];

  // input register stage; ovf_q[0] flags a quotient that would not fit in QUO_W bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= CmpW'(num_i);
      den_q[0]  <= den_i;
      quo_q[0]  <= '0;
      ovf_q[0]  <= CmpW'(num_i) >= (CmpW'(den_i) << QUO_W);
      side_q[0] <= side_i;
    end
  end

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    localparam int B0 = QUO_W - 1 - 2 * s;
    localparam int B1 = B0 - 1;
    logic [CmpW-1:0]  rem_a, rem_b;
    logic [QUO_W-1:0] quo_a, quo_b;

    always_comb begin
      rem_a = rem_q[s];
      quo_a = quo_q[s];
      if (rem_q[s] >= (CmpW'(den_q[s]) << B0)) begin
        rem_a = rem_q[s] - (CmpW'(den_q[s]) << B0);
        quo_a = quo_q[s] | (QUO_W'(1) << B0);
      end
    end

    if (B1 >= 0) begin : g_second
      always_comb begin
        rem_b = rem_a;
        quo_b = quo_a;
        if (rem_a >= (CmpW'(den_q[s]) << B1)) begin
          rem_b = rem_a - (CmpW'(den_q[s]) << B1);
          quo_b = quo_a | (QUO_W'(1) << B1);
        end
      end
    end else begin : g_single
      assign rem_b = rem_a;
      assign quo_b = quo_a;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1]  <= rem_b;
        den_q[s+1]  <= den_q[s];
        quo_q[s+1]  <= quo_b;
        ovf_q[s+1]  <= ovf_q[s];
        side_q[s+1] <= side_q[s];
      end
    end
  end

  assign valid_o = vld_q[Stages];
  assign quo_o   = quo_q[Stages];
  assign ovf_o   = ovf_q[Stages];
  assign side_o  = side_q[Stages];

endmodule

/* hdl/fractal_value_noise_2d.sv */
// top level of the fractal value noise block: octave issue, hash pipeline, blend, accumulate
// depends on fvn_pkg and fvn_div_pipe
//
// One coordinate pair produces one noise beat. The issue stage sends one octave per
// cycle while the output is not stalled into a shared pipeline that hashes the 16
// lattice points around the sample, smooths, blends and scales them, so an item
// occupies the input until its last octave (octave_count of them, 1 to MAX_OCTAVES,
// 8 after reset) issues, and the next item is taken as that last octave issues. The
// delay to out_valid_o comes mostly from the four hash stages and the pipelined ratio
// divider, which runs in both modes.
// A stalled output freezes the whole pipeline; nothing is lost. No setup after reset.
module fractal_value_noise_2d
  import fvn_pkg::*;
#(
  parameter int unsigned MAX_OCTAVES    = MaxOctavesDef,
  parameter int unsigned COS_TABLE_BITS = CosTableBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  fvn_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output fvn_out_t            out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned OctW  = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
  localparam int unsigned SW    = CoordW + MAX_OCTAVES - 1;
  localparam int unsigned IpW   = SW - 16;
  localparam int unsigned FadeN = 1 << COS_TABLE_BITS;
  localparam int unsigned PW    = VW + 18;
  localparam int unsigned NumW  = VW + 15;
  localparam int unsigned DenW  = VW;
  localparam int unsigned P1W   = QuoW + AmpW;
  localparam int unsigned AccW  = NoiseW + OctW + 1;
  localparam int unsigned NSt   = 12;

  localparam logic signed [AccW-1:0] AccMax = AccW'(SumMax);
  localparam logic signed [AccW-1:0] AccMin = AccW'(SumMin);

  typedef struct packed {
    logic                 dz;
    logic signed [VW-1:0] v;
    fvn_tag_t             tag;
  } side_t;

  // ---------------------------------------------------------------- config
  logic [RowMulW-1:0]  row_mul_q;
  logic [OctCntW-1:0]  oct_cnt_q;
  logic [PersistW-1:0] persist_q;
  logic                mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_mul_q <= RowMulRst;
      oct_cnt_q <= OctCntRst;
      persist_q <= PersistRst;
      mode_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgRowMul:  row_mul_q <= cfg_data_i[RowMulW-1:0];
        CfgOctCnt:  oct_cnt_q <= cfg_data_i[OctCntW-1:0];
        CfgPersist: persist_q <= cfg_data_i[PersistW-1:0];
        CfgMode:    mode_q    <= cfg_data_i[0];
      endcase
    end
  end

  // ---------------------------------------------------------------- fade rom
  logic [FadeW-1:0] fade_rom [FadeN];
  for (genvar k = 0; k < FadeN; k++) begin : g_fade
    assign fade_rom[k] = FadeW'(fade_entry(k, COS_TABLE_BITS));
  end

  // ---------------------------------------------------------------- issue
  logic adv;
  logic out_valid_q;
  assign adv = !out_valid_q || !out_stall_i;

  logic                     act_q;
  logic signed [CoordW-1:0] cx0_q, cy0_q;
  logic [OctW-1:0]          oct0_q, last0_q;
  logic [AmpW-1:0]          amp0_q;
  logic [4:0]               cnt_c;
  logic [OctW-1:0]          last_c;
  logic [32:0]              amp_prod;
  logic                     is_last, in_acc;

  always_comb begin
    cnt_c = {1'b0, oct_cnt_q};
    if (cnt_c == 5'd0) cnt_c = 5'd1;
    if (cnt_c > 5'(MAX_OCTAVES)) cnt_c = 5'(MAX_OCTAVES);
    last_c = OctW'(cnt_c - 5'd1);
  end

  assign is_last    = (oct0_q == last0_q);
  assign in_stall_o = !adv || (act_q && !is_last);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign amp_prod   = 33'(amp0_q) * 33'(persist_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
    end else if (in_acc) begin
      act_q <= 1'b1;
    end else if (adv && act_q && is_last) begin
      act_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cx0_q   <= in_data_i.coord_x;
      cy0_q   <= in_data_i.coord_y;
      oct0_q  <= '0;
      last0_q <= last_c;
      amp0_q  <= AmpW'(65536);
    end else if (adv && act_q) begin
      oct0_q <= oct0_q + 1'b1;
      amp0_q <= AmpW'(amp_prod >> 16);
    end
  end

  // ---------------------------------------------------------------- valid and tag line
  logic     vld_q [1:NSt];
  fvn_tag_t tag_q [1:NSt];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 1; s <= NSt; s++) vld_q[s] <= 1'b0;
    end else if (adv) begin
      vld_q[1] <= act_q;
      for (int s = 2; s <= NSt; s++) vld_q[s] <= vld_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tag_q[1] <= '{first: (oct0_q == '0), last: is_last, amp: amp0_q};
      for (int s = 2; s <= NSt; s++) tag_q[s] <= tag_q[s-1];
    end
  end

  // ---------------------------------------------------------------- stage 1: split
  // integer part truncates toward zero, fraction magnitude indexes the fade table
  function automatic logic [31:0] split_ip(input logic signed [SW-1:0] s);
    logic signed [IpW-1:0] hi;
    hi = s[SW-1:16];
    if (s[SW-1] && (s[15:0] != 16'd0)) hi = hi + 1'b1;
    return 32'(hi);
  endfunction

  function automatic logic [COS_TABLE_BITS-1:0] split_idx(input logic signed [SW-1:0] s);
    logic [15:0] fr;
    fr = s[15:0];
    if (s[SW-1] && (s[15:0] != 16'd0)) fr = 16'(17'h10000 - {1'b0, s[15:0]});
    return fr[15 -: COS_TABLE_BITS];
  endfunction

  logic signed [SW-1:0]      sx_c, sy_c;
  logic [31:0]               ix1_q, iy1_q;
  logic [COS_TABLE_BITS-1:0] idxx1_q, idxy1_q;

  assign sx_c = SW'(cx0_q) <<< oct0_q;
  assign sy_c = SW'(cy0_q) <<< oct0_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ix1_q   <= split_ip(sx_c);
      iy1_q   <= split_ip(sy_c);
      idxx1_q <= split_idx(sx_c);
      idxy1_q <= split_idx(sy_c);
    end
  end

  // ---------------------------------------------------------------- stage 2: fade, rows
  logic [FadeW-1:0] fx_q [2:7];
  logic [FadeW-1:0] fy_q [2:9];
  logic [31:0]      xs2_q [4];
  logic [31:0]      ry2_q [4];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fx_q[2] <= fade_rom[idxx1_q];
      fy_q[2] <= fade_rom[idxy1_q];
      for (int s = 3; s <= 7; s++) fx_q[s] <= fx_q[s-1];
      for (int s = 3; s <= 9; s++) fy_q[s] <= fy_q[s-1];
      for (int j = 0; j < 4; j++) begin
        xs2_q[j] <= ix1_q + (32'(j) - 32'd1);
        ry2_q[j] <= (iy1_q + (32'(j) - 32'd1)) * 32'(row_mul_q);
      end
    end
  end

  // ---------------------------------------------------------------- stages 3-6: hash
  // grid entry j*4+k is row iy-1+j, column ix-1+k
  logic [31:0]        n_c   [16];
  logic [31:0]        n3_q  [16];
  logic [31:0]        sq4_q [16], n4_q [16];
  logic [31:0]        t5_q  [16], n5_q [16];
  logic [31:0]        h_c   [16];
  logic signed [31:0] lat6_q [16];

  always_comb begin
    for (int g = 0; g < 16; g++) begin
      n_c[g] = xs2_q[g & 3] + ry2_q[g >> 2];
      h_c[g] = (n5_q[g] * t5_q[g]) + HashOff;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int g = 0; g < 16; g++) begin
        n3_q[g]   <= (n_c[g] << 13) ^ n_c[g];
        sq4_q[g]  <= n3_q[g] * n3_q[g];
        n4_q[g]   <= n3_q[g];
        t5_q[g]   <= (sq4_q[g] * HashMul) + HashAdd;
        n5_q[g]   <= n4_q[g];
        lat6_q[g] <= 32'sh4000_0000 - $signed({1'b0, h_c[g][30:0]});
      end
    end
  end

  // ---------------------------------------------------------------- stage 7: smooth
  logic signed [VW-1:0] smo_c [4];
  logic signed [VW-1:0] smo7_q [4];

  always_comb begin
    int cj;
    int ck;
    for (int p = 0; p < 4; p++) begin
      cj = (p >> 1) + 1;
      ck = (p & 1) + 1;
      smo_c[p] = VW'(lat6_q[(cj-1)*4+ck-1]) + VW'(lat6_q[(cj-1)*4+ck+1])
               + VW'(lat6_q[(cj+1)*4+ck-1]) + VW'(lat6_q[(cj+1)*4+ck+1])
               + ((VW'(lat6_q[cj*4+ck-1]) + VW'(lat6_q[cj*4+ck+1])
                 + VW'(lat6_q[(cj-1)*4+ck]) + VW'(lat6_q[(cj+1)*4+ck])) <<< 1)
               + (VW'(lat6_q[cj*4+ck]) <<< 2);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int p = 0; p < 4; p++) smo7_q[p] <= smo_c[p];
    end
  end

  // ---------------------------------------------------------------- stages 8-11: blend
  function automatic logic signed [VW-1:0] tdiv16(input logic signed [PW:0] x);
    logic signed [PW:0] t;
    t = x;
    if (x[PW]) t = x + (PW+1)'(65535);
    return VW'(t >>> 16);
  endfunction

  logic signed [17:0]   wx1_c, wx0_c, wy1_c, wy0_c;
  logic signed [PW-1:0] px8_q [4];
  logic signed [VW-1:0] r9_q [2];
  logic signed [PW-1:0] py10_q [2];
  logic signed [VW-1:0] v11_q;

  assign wx1_c = $signed({1'b0, fx_q[7]});
  assign wx0_c = 18'sd65536 - wx1_c;
  assign wy1_c = $signed({1'b0, fy_q[9]});
  assign wy0_c = 18'sd65536 - wy1_c;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // along x for both rows, then along y
      px8_q[0]  <= smo7_q[0] * wx0_c;
      px8_q[1]  <= smo7_q[1] * wx1_c;
      px8_q[2]  <= smo7_q[2] * wx0_c;
      px8_q[3]  <= smo7_q[3] * wx1_c;
      r9_q[0]   <= tdiv16((PW+1)'(px8_q[0]) + (PW+1)'(px8_q[1]));
      r9_q[1]   <= tdiv16((PW+1)'(px8_q[2]) + (PW+1)'(px8_q[3]));
      py10_q[0] <= r9_q[0] * wy0_c;
      py10_q[1] <= r9_q[1] * wy1_c;
      v11_q     <= tdiv16((PW+1)'(py10_q[0]) + (PW+1)'(py10_q[1]));
    end
  end

  // ---------------------------------------------------------------- stage 12: ratio prep
  logic signed [VW:0]   den_c;
  logic [VW-1:0]        mag_c;
  logic [NumW-1:0]      num12_q;
  logic [DenW-1:0]      den12_q;
  logic                 dz12_q;
  logic signed [VW-1:0] v12_q;

  assign den_c = (VW+1)'(v11_q) + (VW+1)'(64'sd1 << 34);
  assign mag_c = v11_q[VW-1] ? VW'(-v11_q) : VW'(v11_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      num12_q <= NumW'(mag_c) << 16;
      dz12_q  <= (den_c <= 0);
      den12_q <= (den_c <= 0) ? DenW'(1) : DenW'(den_c);
      v12_q   <= v11_q;
    end
  end

  // ---------------------------------------------------------------- divider
  side_t           side_in, side_out;
  logic            vldd;
  logic [QuoW-1:0] quo;
  logic            ovf;

  assign side_in = '{dz: dz12_q, v: v12_q, tag: tag_q[NSt]};

  fvn_div_pipe #(
    .NUM_W  (NumW),
    .DEN_W  (DenW),
    .QUO_W  (QuoW),
    .SIDE_W ($bits(side_t))
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (vld_q[NSt]),
    .num_i   (num12_q),
    .den_i   (den12_q),
    .side_i  (side_in),
    .valid_o (vldd),
    .quo_o   (quo),
    .ovf_o   (ovf),
    .side_o  (side_out)
  );

  // ---------------------------------------------------------------- term products
  logic                 vldt_q, satt_q;
  fvn_tag_t             tagt_q;
  logic signed [PW-1:0] pt0_q;
  logic [P1W-1:0]       pt1_q;
  logic [QuoW-1:0]      rmag_c;
  logic                 rsat_c;

  assign rsat_c = side_out.dz || ovf;
  assign rmag_c = rsat_c ? QuoW'(SumMax) : quo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vldt_q <= 1'b0;
    end else if (adv) begin
      vldt_q <= vldd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tagt_q <= side_out.tag;
      satt_q <= mode_q && rsat_c;
      pt0_q  <= side_out.v * $signed({1'b0, side_out.tag.amp});
      pt1_q  <= P1W'(rmag_c) * P1W'(side_out.tag.amp);
    end
  end

  // ---------------------------------------------------------------- accumulate
  logic signed [PW-1:0]   t0_c;
  logic signed [AccW-1:0] term_c, acc_sum, acc_q, clamp_c;
  logic                   sacc_q, sat_sum, clip_c;
  fvn_out_t               out_q;

  always_comb begin
    t0_c = pt0_q;
    if (pt0_q[PW-1]) t0_c = pt0_q + PW'((64'd1 << 34) - 64'd1);
    if (mode_q) term_c = AccW'(pt1_q >> 16);
    else        term_c = AccW'(t0_c >>> 34);
    acc_sum = (tagt_q.first ? AccW'(0) : acc_q) + term_c;
    sat_sum = (tagt_q.first ? 1'b0 : sacc_q) || satt_q;
    clip_c  = 1'b0;
    clamp_c = acc_sum;
    if (acc_sum > AccMax) begin
      clamp_c = AccMax;
      clip_c  = 1'b1;
    end else if (acc_sum < AccMin) begin
      clamp_c = AccMin;
      clip_c  = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && vldt_q) begin
      acc_q  <= acc_sum;
      sacc_q <= sat_sum;
    end
    if (adv) begin
      out_q.noise_value <= NoiseW'(clamp_c);
      out_q.saturated   <= sat_sum || clip_c;
    end
  end

  // output beat register; adv means it is empty or being taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= vldt_q && tagt_q.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* tb/testbench.sv */
// self-checking testbench of fractal_value_noise_2d: directed table, then random phases
// depends on fvn_pkg and the block's rtl; predicts each noise beat in plain integer math
module testbench;
  import fvn_pkg::*;

  localparam int unsigned FadeShift  = 16 - CosTableBitsDef;
  localparam int unsigned FadeSize   = 1 << CosTableBitsDef;
  localparam int          ItemsPhase = 225;
  localparam int          CycleLimit = 600000;
  localparam int          DrainWait  = 40;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  fvn_in_t             in_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  fvn_out_t            out_data_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = CfgRowMul;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  // predictor copy of the registers
  logic [RowMulW-1:0]  row_mul = RowMulRst;
  logic [OctCntW-1:0]  oct_cnt = OctCntRst;
  logic [PersistW-1:0] persist = PersistRst;
  logic                multi_mode = 1'b0;

  longint unsigned fade_lut [0:FadeSize];
  fvn_out_t        noise_expected [$];
  int              mismatches = 0;
  int              beats_checked = 0;
  int              cycles = 0;
  bit              calm = 1'b0;
  int              stall_left = 0;
  int              sat_seen = 0;

  fractal_value_noise_2d DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always #2 clk_i = ~clk_i;

  // (1 - cos(pi*t))/2 in q0.16, cosine as taylor series in q30
  function automatic longint unsigned fade_calc(int unsigned k);
    longint unsigned theta, x2, term;
    longint          c, d;
    theta = (64'd3373259426 * k) >> CosTableBitsDef;
    x2    = (theta * theta) >> 30;
    term  = 64'd1 << 30;
    c     = 64'sd1 << 30;
    for (int j = 1; j <= 8; j++) begin
      term = ((term * x2) >> 30) / longint'((2 * j - 1) * (2 * j));
      if (j % 2) c = c - longint'(term);
      else c = c + longint'(term);
    end
    d = (64'sd1 << 30) - c;
    if (d < 0) d = 0;
    return longint'(d + (64'sd1 << 14)) >> 15;
  endfunction

  function automatic longint lattice_val(bit [31:0] x, bit [31:0] y);
    bit [31:0] n, h;
    n = x + y * {16'b0, row_mul};
    n = (n << 13) ^ n;
    h = (n * (n * n * HashMul + HashAdd) + HashOff) & 32'h7fffffff;
    return (64'sd1 << 30) - longint'({32'b0, h});
  endfunction

  function automatic longint smoothed(bit [31:0] x, bit [31:0] y);
    longint corners, sides;
    corners = lattice_val(x - 1, y - 1) + lattice_val(x + 1, y - 1) +
              lattice_val(x - 1, y + 1) + lattice_val(x + 1, y + 1);
    sides   = lattice_val(x - 1, y) + lattice_val(x + 1, y) +
              lattice_val(x, y - 1) + lattice_val(x, y + 1);
    return corners + 2 * sides + 4 * lattice_val(x, y);
  endfunction

  function automatic longint lerp_fade(longint a, longint b, longint f);
    return (a * (65536 - f) + b * f) / 65536;
  endfunction

  function automatic fvn_out_t noise_predict(fvn_in_t it);
    longint    cx, cy, sx, sy, ipx, ipy, frx, fry, fx, fy;
    longint    v, amp, total, den, r, mag;
    bit [31:0] ix, iy;
    int        count;
    bit        sat;
    fvn_out_t  res;
    cx = it.coord_x;
    cy = it.coord_y;
    count = (oct_cnt == 0) ? 1 : (oct_cnt > MaxOctavesDef) ? MaxOctavesDef : oct_cnt;
    amp = 65536;
    total = 0;
    sat = 1'b0;
    for (int i = 0; i < count; i++) begin
      sx = cx * (64'sd1 << i);
      sy = cy * (64'sd1 << i);
      ipx = sx / 65536;
      ipy = sy / 65536;
      frx = sx - ipx * 65536;
      fry = sy - ipy * 65536;
      if (frx < 0) frx = -frx;
      if (fry < 0) fry = -fry;
      fx = fade_lut[frx >> FadeShift];
      fy = fade_lut[fry >> FadeShift];
      ix = ipx[31:0];
      iy = ipy[31:0];
      v = lerp_fade(lerp_fade(smoothed(ix, iy), smoothed(ix + 1, iy), fx),
                    lerp_fade(smoothed(ix, iy + 1), smoothed(ix + 1, iy + 1), fx), fy);
      if (!multi_mode) begin
        total += (v * amp) / (64'sd1 << 34);
      end else begin
        den = v + (64'sd1 << 34);
        if (den <= 0) begin
          mag = SumMax;
          sat = 1'b1;
        end else begin
          r = (v * 65536) / den;
          mag = (r < 0) ? -r : r;
          if (mag > SumMax) begin
            mag = SumMax;
            sat = 1'b1;
          end
        end
        total += (mag * amp) >>> 16;
      end
      amp = (amp * longint'(persist)) >>> 16;
    end
    if (total > SumMax) begin
      total = SumMax;
      sat = 1'b1;
    end else if (total < SumMin) begin
      total = SumMin;
      sat = 1'b1;
    end
    res.noise_value = total[NoiseW-1:0];
    res.saturated = sat;
    return res;
  endfunction

  // caller sits right after a rising edge
  task automatic send_coord(logic signed [CoordW-1:0] x, logic signed [CoordW-1:0] y);
    fvn_in_t it;
    it.coord_x = x;
    it.coord_y = y;
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    noise_expected.push_back(noise_predict(it));
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (noise_expected.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CfgRowMul:  row_mul = val;
      CfgOctCnt:  oct_cnt = val[OctCntW-1:0];
      CfgPersist: persist = val;
      CfgMode:    multi_mode = val[0];
      default: ;
    endcase
  endtask

  // output side: random stall bursts, then compare each beat with the oldest expectation
  always @(posedge clk_i) begin
    fvn_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (noise_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: %0d/%0b",
                                       out_data_o.noise_value, out_data_o.saturated);
      end else begin
        want = noise_expected.pop_front();
        beats_checked++;
        if (want.saturated) sat_seen++;
        if (want.noise_value !== out_data_o.noise_value ||
            want.saturated !== out_data_o.saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("beat %0d: noise exp %0d got %0d, sat exp %0b got %0b",
                     beats_checked, want.noise_value, out_data_o.noise_value,
                     want.saturated, out_data_o.saturated);
        end
      end
    end
    if (calm) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 6) == 0) begin
      stall_left = $urandom_range(0, 4);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  typedef struct {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
  } coord_row_t;

  typedef struct {
    logic [RowMulW-1:0]  rm;
    logic [CfgDataW-1:0] oc;
    logic [PersistW-1:0] pe;
    logic                md;
  } setting_t;

  initial begin
    coord_row_t directed [] = '{
      '{24'sd0, 24'sd0}, '{24'sh7fffff, 24'sh7fffff}, '{-24'sh800000, -24'sh800000},
      '{24'sh7fffff, -24'sh800000}, '{-24'sh800000, 24'sh7fffff}, '{-24'sd1, -24'sd1},
      '{24'sd1, 24'sd1}, '{24'sd4096, -24'sd4096}, '{-24'sd32768, 24'sd32768},
      '{24'sd65536, -24'sd65536}, '{24'sd2048, 24'sd6144}, '{-24'sd2049, 24'sd4095},
      '{24'sh555555, -24'sh2aaaab}, '{24'sd123456, 24'sd654321}
    };
    setting_t phases [] = '{
      '{16'd0, 16'd1, 16'd0, 1'b0}, '{16'hffff, 16'd15, 16'hffff, 1'b1},
      '{16'd599, 16'd0, 16'd32768, 1'b1}, '{16'd12345, 16'd8, 16'hffff, 1'b0},
      '{16'd1, 16'd4, 16'd26214, 1'b1}, '{16'hffff, 16'd8, 16'd0, 1'b0},
      '{16'd777, 16'd3, 16'd50000, 1'b0}, '{16'd599, 16'd8, 16'd26214, 1'b0}
    };
    int sel;
    logic signed [CoordW-1:0] rx, ry;
    for (int k = 0; k <= FadeSize; k++)
      fade_lut[k] = (k <= FadeSize / 2) ? fade_calc(k) : 65536 - fade_calc(FadeSize - k);
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[d]) send_coord(directed[d].x, directed[d].y);
    foreach (phases[p]) begin
      wait_drained();
      write_reg(CfgRowMul, phases[p].rm);
      write_reg(CfgOctCnt, phases[p].oc);
      write_reg(CfgPersist, phases[p].pe);
      write_reg(CfgMode, {15'b0, phases[p].md});
      if (p % 2) send_coord(24'sh7fffff, -24'sh800000);
      for (int n = 0; n < ItemsPhase; n++) begin
        if (p == phases.size() - 1 && n >= ItemsPhase - 150) calm = 1'b1;
        sel = $urandom_range(0, 9);
        if (sel < 3) begin
          rx = CoordW'($urandom);
          ry = CoordW'($urandom);
        end else if (sel < 8) begin
          // near the origin: within two lattice cells of it at the lowest octave
          rx = CoordW'($signed($urandom_range(0, 262143)) - 131072);
          ry = CoordW'($signed($urandom_range(0, 262143)) - 131072);
        end else begin
          rx = $urandom_range(0, 1) ? CoordW'(24'sh7fffff - $urandom_range(0, 255))
                                    : CoordW'(-24'sh800000 + $urandom_range(0, 255));
          ry = $urandom_range(0, 1) ? CoordW'(24'sh7fffff - $urandom_range(0, 255))
                                    : CoordW'(-24'sh800000 + $urandom_range(0, 255));
        end
        send_coord(rx, ry);
      end
    end
    wait_drained();
    $display("checked %0d noise beats over %0d register settings, %0d of them saturated",
             beats_checked, phases.size() + 1, sat_seen);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
